/* hw/rtl/pvps_pkg.sv */
package pvps_pkg;

  localparam int ATAN_BITS = 32;
  localparam int MAX_STEPS = 24;
  localparam int MAX_FACTOR = 4;
  localparam int FACT_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam int CW = 68;
  localparam logic [31:0] GAIN_Q31 = 32'h4DBA76D4;

  function automatic logic [31:0] atan_lut(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CW-1:0] sat32(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > $signed({{(CW-32){1'b0}}, 32'h7FFFFFFF})) r = {{(CW-32){1'b0}}, 32'h7FFFFFFF};
    else if (v < $signed({{(CW-32){1'b1}}, 32'h80000000})) r = {{(CW-32){1'b1}}, 32'h80000000};
    else r = v;
    return r;
  endfunction

endpackage

/* hw/rtl/pvps_cordic_stage.sv */
module pvps_cordic_stage #(
  parameter int SHIFT = 0,
  parameter int PB = 16,
  parameter int NB = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_in,
  input  logic vect,
  input  logic signed [pvps_pkg::CW-1:0] x_in,
  input  logic signed [pvps_pkg::CW-1:0] y_in,
  input  logic [31:0] z_in,
  input  logic [PB-1:0] aux_in,
  input  logic [$clog2(NB)-1:0] idx_in,
  input  logic [pvps_pkg::FACT_BITS-1:0] f_in,
  input  logic flip_in,
  input  logic emit_in,
  output logic vld_out,
  output logic signed [pvps_pkg::CW-1:0] x_out,
  output logic signed [pvps_pkg::CW-1:0] y_out,
  output logic [31:0] z_out,
  output logic [PB-1:0] aux_out,
  output logic [$clog2(NB)-1:0] idx_out,
  output logic [pvps_pkg::FACT_BITS-1:0] f_out,
  output logic flip_out,
  output logic emit_out
);
  localparam logic [4:0] K = 5'(SHIFT);
  logic [31:0] at;
  logic signed [pvps_pkg::CW-1:0] dx, dy;
  logic dir;
  assign at = pvps_pkg::atan_lut(K);
  assign dx = y_in >>> SHIFT;
  assign dy = x_in >>> SHIFT;
  // Vectoring drives y toward zero; rotation drives z toward zero.
  assign dir = vect ? !y_in[pvps_pkg::CW-1] : z_in[31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aux_out <= aux_in;
      idx_out <= idx_in;
      f_out <= f_in;
      flip_out <= flip_in;
      emit_out <= emit_in;
      if (vect == dir) begin
        x_out <= vect ? x_in + dx : x_in - dx;
        y_out <= vect ? y_in - dy : y_in + dy;
        z_out <= vect ? z_in + at : z_in - at;
      end else begin
        x_out <= vect ? x_in - dx : x_in + dx;
        y_out <= vect ? y_in + dy : y_in - dy;
        z_out <= vect ? z_in - at : z_in + at;
      end
    end
  end
endmodule

/* hw/rtl/pvps_front.sv */
module pvps_front #(
  parameter int NB = 8,
  parameter int PB = 16,
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  logic signed [31:0] in_re,
  input  logic signed [31:0] in_im,
  output logic vld_o,
  output logic [31:0] mag_o,
  output logic [PB-1:0] phs_o,
  output logic [$clog2(NB)-1:0] idx_o
);
  localparam int CW = pvps_pkg::CW;
  localparam int IB = $clog2(NB);
  localparam int NS = (STEPS < pvps_pkg::MAX_STEPS) ? STEPS : pvps_pkg::MAX_STEPS;

  logic [IB-1:0] cnt_r, cnt_nxt;
  logic signed [CW-1:0] xs [NS+1];
  logic signed [CW-1:0] ys [NS+1];
  logic [31:0] zs [NS+1];
  logic [IB-1:0] is [NS+1];
  logic vs [NS+1];
  logic zs_flag [NS+1];
  logic [PB-1:0] ax [NS+1];
  logic [pvps_pkg::FACT_BITS-1:0] fx [NS+1];
  logic fl [NS+1];
  logic neg;

  assign cnt_nxt = (32'(cnt_r) + 1 >= NB) ? '0 : cnt_r + 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (en && in_valid) cnt_r <= cnt_nxt;
  end

  assign neg = in_re[31];
  assign vs[0] = in_valid;
  assign xs[0] = neg ? -CW'(in_re) : CW'(in_re);
  assign ys[0] = neg ? -CW'(in_im) : CW'(in_im);
  assign zs[0] = neg ? 32'h80000000 : 32'h0;
  assign is[0] = cnt_r;
  assign zs_flag[0] = (in_re == 0) && (in_im == 0);
  assign ax[0] = '0;
  assign fx[0] = '0;
  assign fl[0] = 1'b0;

  for (genvar g = 0; g < NS; g++) begin : g_st
    pvps_cordic_stage #(.SHIFT(g), .PB(PB), .NB(NB)) u_st (
      .clk, .rst_n, .en, .vld_in(vs[g]), .vect(1'b1),
      .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]), .aux_in(ax[g]), .idx_in(is[g]),
      .f_in(fx[g]), .flip_in(fl[g]), .emit_in(zs_flag[g]),
      .vld_out(vs[g+1]), .x_out(xs[g+1]), .y_out(ys[g+1]), .z_out(zs[g+1]),
      .aux_out(ax[g+1]), .idx_out(is[g+1]), .f_out(fx[g+1]), .flip_out(fl[g+1]),
      .emit_out(zs_flag[g+1]));
  end

  // Gain removal stage. The vectored x can exceed 32 bits, so 33 bits enter the multiply.
  logic [CW-1:0] xc;
  logic [63:0] prod;
  logic [32:0] rnd;
  assign xc = xs[NS][CW-1] ? '0 : xs[NS];
  assign prod = 64'(xc[32:0]) * 64'(pvps_pkg::GAIN_Q31);
  logic [32:0] ph_r;
  assign ph_r = {1'b0, zs[NS]} + (33'd1 << (31 - PB));
  assign rnd = 33'((prod + 64'h40000000) >> 31);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_o <= 1'b0;
    else if (en) vld_o <= vs[NS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      idx_o <= is[NS];
      mag_o <= zs_flag[NS] ? '0 : rnd[31:0];
      phs_o <= zs_flag[NS] ? '0 : ph_r[31 -: PB];
    end
  end
endmodule

/* hw/rtl/pvps_back.sv */
module pvps_back #(
  parameter int NB = 8,
  parameter int PB = 16,
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  logic [31:0] mag_i,
  input  logic [PB-1:0] phs_i,
  input  logic [$clog2(NB)-1:0] idx_i,
  input  logic [pvps_pkg::FACT_BITS-1:0] f_i,
  output logic vld_o,
  output logic signed [31:0] re_o,
  output logic signed [31:0] im_o,
  output logic [$clog2(NB)-1:0] bin_o,
  output logic [pvps_pkg::FACT_BITS-1:0] f_o
);
  localparam int CW = pvps_pkg::CW;
  localparam int IB = $clog2(NB);
  localparam int NS = (STEPS < pvps_pkg::MAX_STEPS) ? STEPS : pvps_pkg::MAX_STEPS;

  logic [PB-1:0] prev_r [NB];
  logic [PB-1:0] acc_r [NB];
  logic [PB-1:0] dph;
  logic [PB+2:0] dm;
  logic [IB+2:0] binw;
  logic emit;
  logic [PB-1:0] nacc;
  logic [IB-1:0] bin;

  assign dph = phs_i - prev_r[idx_i];
  assign dm = (PB+3)'(dph) * (PB+3)'(f_i);
  assign binw = (IB+3)'(idx_i) * (IB+3)'(f_i);
  assign bin = binw[IB-1:0];
  assign emit = (f_i != 0) && (32'(binw) < NB);
  assign nacc = acc_r[bin] + dm[PB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NB; k++) begin
        prev_r[k] <= '0;
        acc_r[k] <= '0;
      end
    end else if (en && vld_i) begin
      prev_r[idx_i] <= phs_i;
      if (emit) acc_r[bin] <= nacc;
    end
  end

  // Stage 0: gain pre-scale of magnitude and quadrant fold.
  logic [63:0] prod;
  logic [31:0] a;
  logic flip0;
  logic [31:0] z0;
  assign prod = mag_i * pvps_pkg::GAIN_Q31;
  assign a = 32'(nacc) << (32 - PB);
  assign flip0 = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
  assign z0 = flip0 ? a - 32'h80000000 : a;

  logic v0_r, fl0_r, em0_r;
  logic [31:0] x0_r, z0_r;
  logic [IB-1:0] b0_r;
  logic [pvps_pkg::FACT_BITS-1:0] f0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= vld_i && emit;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= 32'((prod + 64'h40000000) >> 31);
      z0_r <= z0;
      fl0_r <= flip0;
      em0_r <= 1'b1;
      b0_r <= bin;
      f0_r <= f_i;
    end
  end

  logic signed [CW-1:0] xs [NS+1];
  logic signed [CW-1:0] ys [NS+1];
  logic [31:0] zs [NS+1];
  logic [IB-1:0] bs [NS+1];
  logic vs [NS+1];
  logic ems [NS+1];
  logic [PB-1:0] ax [NS+1];
  logic [pvps_pkg::FACT_BITS-1:0] fs [NS+1];
  logic fls [NS+1];
  assign vs[0] = v0_r;
  assign xs[0] = CW'(x0_r);
  assign ys[0] = '0;
  assign zs[0] = z0_r;
  assign bs[0] = b0_r;
  assign fs[0] = f0_r;
  assign fls[0] = fl0_r;
  assign ems[0] = em0_r;
  assign ax[0] = '0;

  for (genvar g = 0; g < NS; g++) begin : g_st
    pvps_cordic_stage #(.SHIFT(g), .PB(PB), .NB(NB)) u_st (
      .clk, .rst_n, .en, .vld_in(vs[g]), .vect(1'b0),
      .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]), .aux_in(ax[g]), .idx_in(bs[g]),
      .f_in(fs[g]), .flip_in(fls[g]), .emit_in(ems[g]),
      .vld_out(vs[g+1]), .x_out(xs[g+1]), .y_out(ys[g+1]), .z_out(zs[g+1]),
      .aux_out(ax[g+1]), .idx_out(bs[g+1]), .f_out(fs[g+1]), .flip_out(fls[g+1]),
      .emit_out(ems[g+1]));
  end

  logic signed [CW-1:0] xf, yf, xsat, ysat;
  assign xf = fls[NS] ? -xs[NS] : xs[NS];
  assign yf = fls[NS] ? -ys[NS] : ys[NS];
  assign xsat = pvps_pkg::sat32(xf);
  assign ysat = pvps_pkg::sat32(yf);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_o <= 1'b0;
    else if (en) vld_o <= vs[NS] && ems[NS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      re_o <= xsat[31:0];
      im_o <= ysat[31:0];
      bin_o <= bs[NS];
      f_o <= fs[NS];
    end
  end
endmodule

/* hw/rtl/pvps_emit.sv */
module pvps_emit #(
  parameter int NB = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic signed [31:0] re_i,
  input  logic signed [31:0] im_i,
  input  logic [$clog2(NB)-1:0] bin_i,
  input  logic [pvps_pkg::FACT_BITS-1:0] f_i,
  output logic [2:0] used_o,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] out_index,
  output logic signed [31:0] out_real,
  output logic signed [31:0] out_imag,
  output logic run_last
);
  localparam int IB = $clog2(NB);
  localparam int QD = 4;
  logic signed [31:0] qre [QD];
  logic signed [31:0] qim [QD];
  logic [IB-1:0] qbin [QD];
  logic [pvps_pkg::FACT_BITS-1:0] qf [QD];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [pvps_pkg::FACT_BITS-1:0] sub_r, sub_nxt;
  logic pop, done;
  logic [IB+2:0] cur;
  logic [IB+2:0] nxt_bin;

  assign out_valid = cnt_r != 0;
  assign cur = (IB+3)'(qbin[rp_r]) + (IB+3)'(sub_r);
  assign nxt_bin = cur + 1'b1;
  // A run ends at the pitch factor or at the frame edge.
  assign done = (32'(sub_r) + 1 >= 32'(qf[rp_r])) || (32'(nxt_bin) >= NB);
  assign pop = out_valid && out_ready && done;
  assign out_index = 3'(cur);
  assign out_real = (sub_r == 0) ? qre[rp_r] : '0;
  assign out_imag = (sub_r == 0) ? qim[rp_r] : '0;
  assign run_last = done;
  assign used_o = cnt_r;
  assign cnt_nxt = cnt_r + 3'(push) - 3'(pop);
  assign sub_nxt = (out_valid && out_ready) ? (done ? '0 : sub_r + 1'b1) : sub_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      sub_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (push) begin
      qre[wp_r] <= re_i;
      qim[wp_r] <= im_i;
      qbin[wp_r] <= bin_i;
      qf[wp_r] <= f_i;
    end
  end
endmodule

/* hw/rtl/phase_vocoder_pitch_shift_top.sv */
// Channel  | Handshake              | Payload
// in       | in_valid / in_ready    | in_bin_real, in_bin_imag
// out      | out_valid / out_ready  | out_index, out_real, out_imag, run_last
// cfg      | cfg_we                 | cfg_data (pitch factor)
// A polar and a rectangular CORDIC pipeline, one stage per step, run back to back with
// two gain stages and an output register.
// An input word is taken every cycle while the result queue holds fewer than three bins
// or no result waits to enter it; each queued bin then fills a run of up to the pitch
// factor output indices. The pipeline freezes as a whole when the queue is held up.
// Reset is synchronous and clears all phase memories and the bin counter.
module phase_vocoder_pitch_shift_top #(
  parameter int NUM_BINS = 8,
  parameter int PHASE_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] in_bin_real,
  input  logic signed [31:0] in_bin_imag,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] out_index,
  output logic signed [31:0] out_real,
  output logic signed [31:0] out_imag,
  output logic run_last,
  input  logic cfg_we,
  input  logic [2:0] cfg_data
);
  localparam int IB = $clog2(NUM_BINS);
  logic [2:0] pf_r;
  logic [2:0] f_eff;
  logic en;
  logic fv;
  logic [31:0] fmag;
  logic [PHASE_BITS-1:0] fphs;
  logic [IB-1:0] fidx;
  logic bv;
  logic signed [31:0] bre, bim;
  logic [IB-1:0] bbin;
  logic [2:0] bf;
  logic [2:0] used;

  always_ff @(posedge clk) begin
    if (!rst_n) pf_r <= 3'd2;
    else if (cfg_we) pf_r <= cfg_data;
  end
  assign f_eff = (pf_r > 3'(pvps_pkg::MAX_FACTOR)) ? 3'(pvps_pkg::MAX_FACTOR) : pf_r;

  // Simple conservative stall: advance only while the queue holds fewer than three bins or no result waits to enter it.
  assign en = (used < 3'd3) || !bv;
  assign in_ready = en;

  pvps_front #(.NB(NUM_BINS), .PB(PHASE_BITS), .STEPS(CORDIC_STEPS)) u_front (
    .clk, .rst_n, .en, .in_valid, .in_re(in_bin_real), .in_im(in_bin_imag),
    .vld_o(fv), .mag_o(fmag), .phs_o(fphs), .idx_o(fidx));

  pvps_back #(.NB(NUM_BINS), .PB(PHASE_BITS), .STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .en, .vld_i(fv), .mag_i(fmag), .phs_i(fphs), .idx_i(fidx),
    .f_i(f_eff), .vld_o(bv), .re_o(bre), .im_o(bim), .bin_o(bbin), .f_o(bf));

  pvps_emit #(.NB(NUM_BINS)) u_emit (
    .clk, .rst_n, .push(bv && en), .re_i(bre), .im_i(bim), .bin_i(bbin), .f_i(bf),
    .used_o(used), .out_valid, .out_ready, .out_index, .out_real, .out_imag,
    .run_last);

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) used <= 3'd4)
    else $error("result queue overflow");
  a_noemit: assert property (@(posedge clk) disable iff (!rst_n)
    (used == 3'd0) |-> !out_valid) else $error("output without queued bin");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !run_last) |-> (out_index != 3'(NUM_BINS - 1)))
    else $error("run not closed at frame edge");
endmodule
